/* src/dual_encoder_speed_meter_top_macros.svh */
// assertion helpers shared by the speed meter modules
`ifndef DUAL_ENCODER_SPEED_METER_TOP_MACROS_SVH
`define DUAL_ENCODER_SPEED_METER_TOP_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define DESM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DESM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/desm_pkg.sv */
package desm_pkg;

  // configuration register geometry
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CIRC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PPR  = 1'b1;

  localparam logic [CFG_W-1:0] CIRC_RESET = 12'd210;
  localparam logic [CFG_W-1:0] PPR_RESET  = 12'd20;

  // request kinds carried in tuser
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_WINDOW = 1'b1;

  // speed result: 15-bit magnitude, saturating at 32767, then signed
  localparam int SPEED_W  = 16;
  localparam int QUO_BITS = 15;
  localparam int STEP_W   = $clog2(QUO_BITS);

  // scale by 1000 as (x << 10) - (x << 4) - (x << 3)
  localparam int SCALE_W   = 10;
  localparam int SCALE_SH0 = 10;
  localparam int SCALE_SH1 = 4;
  localparam int SCALE_SH2 = 3;

  // per-lane commands from the merge stage
  typedef struct packed {
    logic sample;
    logic window;
    logic ack;
  } lane_ctrl_t;

  // per-lane status back to the merge stage
  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

/* src/dual_encoder_speed_meter_top.sv */
// channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | tuser: req_type; tdata: enc_l, enc_r, cmd_l, cmd_r
// out_    | out | out_tvalid/out_tready| tdata: speed_left, speed_right
// cfg_    | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// a sample transfer updates both edge counters at once
// a window transfer reaches the output register through product, x1000 scale,
// range check, then the restoring divider in each lane (skipped in a lane whose
// result is zero or saturated)
// input is held off while a lane computes or holds a result the output register cannot take
// reset (synchronous, rst_n low) clears counters, levels, registers to 210 / 20, output empty
module dual_encoder_speed_meter_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [23:0]                         in_tdata,   // enc_left, enc_right, cmd_left, cmd_right, pad
  input  logic [0:0]                          in_tuser,   // req_type
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [31:0]                         out_tdata,  // speed_left, speed_right
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [desm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [desm_pkg::CFG_W-1:0]          cfg_data
);

  logic [desm_pkg::CFG_W-1:0]   circ_r, circ_nxt;
  logic [desm_pkg::CFG_W-1:0]   ppr_r, ppr_nxt;
  logic                         out_tvalid_r, out_tvalid_nxt;
  logic [31:0]                  out_tdata_r, out_tdata_nxt;
  logic                         in_xfer;
  logic                         load;
  desm_pkg::lane_ctrl_t         ctrl;
  desm_pkg::lane_stat_t         stat_l, stat_r;
  logic [desm_pkg::SPEED_W-1:0] speed_l, speed_r;

  // configuration writes
  assign cfg_ready = 1'b1;
  always_comb begin
    circ_nxt = circ_r;
    ppr_nxt  = ppr_r;
    if (cfg_valid) begin
      case (cfg_index)
        desm_pkg::REG_CIRC: circ_nxt = cfg_data;
        desm_pkg::REG_PPR:  ppr_nxt  = cfg_data;
        default: begin
        end
      endcase
    end
  end

  // input handshake and lane commands
  assign in_tready   = !stat_l.busy && !stat_l.done && !stat_r.busy && !stat_r.done;
  assign in_xfer     = in_tvalid && in_tready;
  assign load        = stat_l.done && stat_r.done && (!out_tvalid_r || out_tready);
  assign ctrl.sample = in_xfer && (in_tuser[0] == desm_pkg::REQ_SAMPLE);
  assign ctrl.window = in_xfer && (in_tuser[0] == desm_pkg::REQ_WINDOW);
  assign ctrl.ack    = load;

  desm_lane #(
    .COUNT_BITS (COUNT_BITS)
  ) u_lane_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .level   (in_tdata[0]),
    .cmd_neg (in_tdata[9]),
    .circ    (circ_r),
    .ppr     (ppr_r),
    .stat    (stat_l),
    .speed   (speed_l)
  );

  desm_lane #(
    .COUNT_BITS (COUNT_BITS)
  ) u_lane_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (ctrl),
    .level   (in_tdata[1]),
    .cmd_neg (in_tdata[17]),
    .circ    (circ_r),
    .ppr     (ppr_r),
    .stat    (stat_r),
    .speed   (speed_r)
  );

  // merge both lane results into the output register
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    if (load) begin
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {speed_r, speed_l};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_r       <= desm_pkg::CIRC_RESET;
      ppr_r        <= desm_pkg::PPR_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      circ_r       <= circ_nxt;
      ppr_r        <= ppr_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

`include "dual_encoder_speed_meter_top_macros.svh"

  `DESM_ASSERT_SAME(a_out_held, out_tvalid_r && !out_tready, !load, "output overwritten while stalled")
  `DESM_ASSERT_NEXT(a_window_starts, ctrl.window, stat_l.busy && stat_r.busy, "window transfer did not start both lanes")
  `DESM_ASSERT_NEXT(a_load_fills_out, load, out_tvalid, "merged result not presented")

endmodule

/* src/desm_lane.sv */
module desm_lane #(
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  desm_pkg::lane_ctrl_t            ctrl,
  input  logic                            level,
  input  logic                            cmd_neg,
  input  logic [desm_pkg::CFG_W-1:0]      circ,
  input  logic [desm_pkg::CFG_W-1:0]      ppr,
  output desm_pkg::lane_stat_t            stat,
  output logic [desm_pkg::SPEED_W-1:0]    speed
);

  localparam int PROD_W = COUNT_BITS + desm_pkg::CFG_W;
  localparam int NUM_W  = PROD_W + desm_pkg::SCALE_W;
  localparam int DEN_W  = desm_pkg::CFG_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                       state_r, state_nxt;
  logic                             last_r, last_nxt;
  logic [COUNT_BITS-1:0]            count_r, count_nxt;
  logic [PROD_W-1:0]                prod_r, prod_nxt;
  logic [NUM_W-1:0]                 rem_r, rem_nxt;
  logic [NUM_W-1:0]                 d_r, d_nxt;
  logic [DEN_W-1:0]                 den_r, den_nxt;
  logic [desm_pkg::QUO_BITS-1:0]    q_r, q_nxt;
  logic [desm_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic                             neg_r, neg_nxt;
  logic [NUM_W-1:0]                 prod_ext;
  logic [NUM_W-1:0]                 den_ext;
  logic [desm_pkg::SPEED_W-1:0]     mag;

  assign prod_ext = NUM_W'(prod_r);
  assign den_ext  = NUM_W'(den_r);

  // edge counting, snapshot and the speed sequencer
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    d_nxt     = d_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    neg_nxt   = neg_r;

    // any level change counts as one edge, wrapping
    if (ctrl.sample && (level != last_r)) begin
      count_nxt = count_r + COUNT_BITS'(1);
      last_nxt  = level;
    end

    case (state_r)
      S_IDLE: begin
        if (ctrl.window) begin
          prod_nxt  = PROD_W'(count_r) * PROD_W'(circ);
          den_nxt   = {ppr, 1'b0};
          neg_nxt   = cmd_neg;
          count_nxt = '0;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        rem_nxt   = (prod_ext << desm_pkg::SCALE_SH0) - (prod_ext << desm_pkg::SCALE_SH1)
                    - (prod_ext << desm_pkg::SCALE_SH2);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // zero numerator, saturation, or a real division
        if (rem_r == '0) begin
          q_nxt     = '0;
          state_nxt = S_DONE;
        end else if (rem_r >= (den_ext << desm_pkg::QUO_BITS)) begin
          q_nxt     = '1;
          state_nxt = S_DONE;
        end else begin
          d_nxt     = den_ext << (desm_pkg::QUO_BITS - 1);
          q_nxt     = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // one restoring quotient bit per cycle, msb first
        if (rem_r >= d_r) begin
          rem_nxt = rem_r - d_r;
          q_nxt   = {q_r[desm_pkg::QUO_BITS-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[desm_pkg::QUO_BITS-2:0], 1'b0};
        end
        d_nxt    = d_r >> 1;
        step_nxt = step_r + desm_pkg::STEP_W'(1);
        if (step_r == desm_pkg::STEP_W'(desm_pkg::QUO_BITS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (ctrl.ack) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
  end

  // signed result
  assign mag   = {1'b0, q_r};
  assign speed = neg_r ? (desm_pkg::SPEED_W'(0) - mag) : mag;

  assign stat.busy = (state_r != S_IDLE) && (state_r != S_DONE);
  assign stat.done = (state_r == S_DONE);

`include "dual_encoder_speed_meter_top_macros.svh"

  `DESM_ASSERT_SAME(a_window_from_idle, ctrl.window, state_r == S_IDLE, "window start while lane active")
  `DESM_ASSERT_SAME(a_div_rem_bound, state_r == S_DIV, {1'b0, rem_r} < {d_r, 1'b0}, "division remainder out of range")
  `DESM_ASSERT_NEXT(a_ack_releases, ctrl.ack, state_r == S_IDLE, "lane not released after ack")

endmodule
